// File: hdl/utf8_to_json_string_escaper_top_assert.svh
// assertion macros for the utf-8 to json string escaper top level
`ifndef UTF8_TO_JSON_STRING_ESCAPER_TOP_ASSERT_SVH
`define UTF8_TO_JSON_STRING_ESCAPER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define U2J_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define U2J_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/u2j_pkg.sv
// shared types, character codes and helpers for the utf-8 to json escaper
`default_nettype none

package u2j_pkg;

    localparam int MAX_RESULTS = 14;
    localparam int BODY_MAX    = 12;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // configuration register indexes
    localparam int REG_CHECK_OVERLONG = 0;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_MALFORMED = 2'd1,
        ERR_OVERLONG  = 2'd2,
        ERR_SURROGATE = 2'd3
    } t_err;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [20:0] CP_TAB = 21'h09;
    localparam logic [20:0] CP_LF  = 21'h0A;
    localparam logic [20:0] CP_CR  = 21'h0D;
    localparam logic [20:0] CP_MAX = 21'h10FFFF;

    // uppercase ascii hex digit
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        if (v < 4'd10) begin
            return 8'h30 + {4'b0, v};
        end
        return 8'h37 + {4'b0, v};
    endfunction

endpackage

`default_nettype wire

// File: hdl/utf8_to_json_string_escaper_top.sv
// top level of the utf-8 to json string literal escaper
`default_nettype none

// Takes a UTF-8 string one byte per request on the slave stream and sends the
// bytes of the quoted JSON string literal on the master stream, one byte per
// cycle while the master is ready. Slave tdata is the raw byte, tuser[0] says
// the byte is present, tuser[1] opens a new string, tlast closes it. Master
// tlast marks the last result of one input request; a nonzero master tuser is
// an error result (1 malformed, 2 overlong, 3 encoded surrogate) with tdata
// zero, after which the rest of the string is dropped and no closing quote
// follows. A request is registered, decoded and expanded into up to 14 result
// bytes in one pass, then shifted out of a result register one byte a cycle
// while the master is ready. An item gives one result byte for a plain ASCII
// byte, six for a \uHHHH escape, twelve for a surrogate pair, plus quotes;
// items with no result are taken without loading the result register. The
// next request is taken while the last byte of the previous one is being
// sent, so the output port sets the rate. A request passes the input register
// and then the result register before its first result is on the master port.
// check_overlong sits at byte address 0 of the register port (reset 1).
module utf8_to_json_string_escaper_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input byte stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_axis_tuser,   // [0] carries_byte, [1] string_start
    input  wire logic        s_axis_tlast,   // string_end
    // escaped output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]       m_axis_tuser,   // [1:0] error_code
    output logic             m_axis_tlast,   // run_last
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CW = u2j_pkg::CNT_W;

    // register port: a single register, so every word address hits it
    logic r_check;
    logic reg_wr;
    logic [1:0] unused_addr;

    assign pready      = 1'b1;
    assign reg_wr      = psel && penable && pwrite && pready;
    assign unused_addr = paddr;
    assign prdata      = {31'b0, r_check};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check <= 1'b1;
        end else if (reg_wr) begin
            r_check <= pwdata[0];
        end
    end

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_carries;
    logic       r_in_start;
    logic       r_in_end;
    logic       consume;

    assign s_axis_tready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte    <= s_axis_tdata;
            r_in_carries <= s_axis_tuser[0];
            r_in_start   <= s_axis_tuser[1];
            r_in_end     <= s_axis_tlast;
        end
    end

    // decoder state
    logic [20:0] r_acc;
    logic [1:0]  r_pend;
    logic [1:0]  r_len;
    logic        r_skip;
    logic [20:0] n_acc;
    logic [1:0]  n_pend;
    logic [1:0]  n_len;
    logic        n_skip;

    // per-request decode
    logic [20:0]     st_acc;
    logic [1:0]      st_pend;
    logic [1:0]      st_len;
    logic            take;
    logic [20:0]     acc_sh;
    logic [1:0]      pend_dec;
    logic            overlong;
    logic            do_emit;
    logic [20:0]     emit_cp;
    u2j_pkg::t_err   byte_err;
    logic            tail_quote;
    u2j_pkg::t_err   tail_err;
    logic            tail_any;

    always_comb begin
        st_acc   = r_in_start ? 21'd0 : r_acc;
        st_pend  = r_in_start ? 2'd0  : r_pend;
        st_len   = r_in_start ? 2'd0  : r_len;
        n_acc    = st_acc;
        n_pend   = st_pend;
        n_len    = st_len;
        n_skip   = r_in_start ? 1'b0 : r_skip;
        take     = r_in_carries && !n_skip;
        acc_sh   = {st_acc[14:0], r_in_byte[5:0]};
        pend_dec = st_pend - 2'd1;
        do_emit  = 1'b0;
        emit_cp  = {13'b0, r_in_byte};
        byte_err = u2j_pkg::ERR_NONE;
        overlong = 1'b0;

        unique case (st_len)
            2'd1:    overlong = (acc_sh[20:7] == 14'd0);
            2'd2:    overlong = (acc_sh[20:11] == 10'd0);
            default: overlong = (acc_sh[20:16] == 5'd0);
        endcase

        if (take) begin
            if (st_pend == 2'd0) begin
                if (!r_in_byte[7]) begin
                    do_emit = 1'b1;
                end else if (r_in_byte[7:5] == 3'b110) begin
                    n_acc  = {16'b0, r_in_byte[4:0]};
                    n_pend = 2'd1;
                    n_len  = 2'd1;
                end else if (r_in_byte[7:4] == 4'b1110) begin
                    n_acc  = {17'b0, r_in_byte[3:0]};
                    n_pend = 2'd2;
                    n_len  = 2'd2;
                end else if (r_in_byte[7:3] == 5'b11110) begin
                    n_acc  = {18'b0, r_in_byte[2:0]};
                    n_pend = 2'd3;
                    n_len  = 2'd3;
                end else begin
                    byte_err = u2j_pkg::ERR_MALFORMED;
                end
            end else if (r_in_byte[7:6] != 2'b10) begin
                byte_err = u2j_pkg::ERR_MALFORMED;
            end else if (pend_dec != 2'd0) begin
                n_acc  = acc_sh;
                n_pend = pend_dec;
            end else begin
                // sequence complete: overlong, range, then surrogate
                n_acc   = 21'd0;
                n_pend  = 2'd0;
                n_len   = 2'd0;
                emit_cp = acc_sh;
                if (r_check && overlong) begin
                    byte_err = u2j_pkg::ERR_OVERLONG;
                end else if (acc_sh > u2j_pkg::CP_MAX) begin
                    byte_err = u2j_pkg::ERR_MALFORMED;
                end else if (acc_sh[20:11] == 10'h01B) begin
                    byte_err = u2j_pkg::ERR_SURROGATE;
                end else begin
                    do_emit = 1'b1;
                end
            end
        end

        if (byte_err != u2j_pkg::ERR_NONE) begin
            n_skip = 1'b1;
            n_acc  = 21'd0;
            n_pend = 2'd0;
            n_len  = 2'd0;
        end

        // string end: closing quote, or an error if a sequence is cut short
        tail_quote = 1'b0;
        tail_err   = u2j_pkg::ERR_NONE;
        if (r_in_end) begin
            if (!n_skip) begin
                if (n_pend != 2'd0) begin
                    tail_err = u2j_pkg::ERR_MALFORMED;
                end else begin
                    tail_quote = 1'b1;
                end
            end
            n_acc  = 21'd0;
            n_pend = 2'd0;
            n_len  = 2'd0;
            n_skip = 1'b0;
        end
        tail_any = tail_quote || (tail_err != u2j_pkg::ERR_NONE);
    end

    // expansion of one code point into its escaped bytes
    logic [7:0]  body [u2j_pkg::BODY_MAX];
    logic [3:0]  body_len;
    logic [19:0] supp;
    logic [15:0] hi_unit;
    logic [15:0] lo_unit;

    assign supp    = 20'(emit_cp - 21'h10000);
    assign hi_unit = {6'b110110, supp[19:10]};
    assign lo_unit = {6'b110111, supp[9:0]};

    always_comb begin
        for (int i = 0; i < u2j_pkg::BODY_MAX; i++) begin
            body[i] = u2j_pkg::CH_NUL;
        end
        body_len = 4'd0;
        if (byte_err != u2j_pkg::ERR_NONE) begin
            body_len = 4'd1;
        end else if (do_emit) begin
            if (emit_cp == {13'b0, u2j_pkg::CH_QUOTE}
                    || emit_cp == {13'b0, u2j_pkg::CH_BSLASH}) begin
                body[0]  = u2j_pkg::CH_BSLASH;
                body[1]  = emit_cp[7:0];
                body_len = 4'd2;
            end else if (emit_cp[20:7] == 14'd0 && emit_cp[6:5] != 2'b00) begin
                body[0]  = emit_cp[7:0];
                body_len = 4'd1;
            end else if (emit_cp == u2j_pkg::CP_CR) begin
                body[0]  = u2j_pkg::CH_BSLASH;
                body[1]  = u2j_pkg::CH_R;
                body_len = 4'd2;
            end else if (emit_cp == u2j_pkg::CP_LF) begin
                body[0]  = u2j_pkg::CH_BSLASH;
                body[1]  = u2j_pkg::CH_N;
                body_len = 4'd2;
            end else if (emit_cp == u2j_pkg::CP_TAB) begin
                body[0]  = u2j_pkg::CH_BSLASH;
                body[1]  = u2j_pkg::CH_T;
                body_len = 4'd2;
            end else if (emit_cp[20:16] == 5'd0) begin
                body[0]  = u2j_pkg::CH_BSLASH;
                body[1]  = u2j_pkg::CH_U;
                body[2]  = u2j_pkg::hex_digit(emit_cp[15:12]);
                body[3]  = u2j_pkg::hex_digit(emit_cp[11:8]);
                body[4]  = u2j_pkg::hex_digit(emit_cp[7:4]);
                body[5]  = u2j_pkg::hex_digit(emit_cp[3:0]);
                body_len = 4'd6;
            end else begin
                // surrogate pair
                body[0]  = u2j_pkg::CH_BSLASH;
                body[1]  = u2j_pkg::CH_U;
                body[2]  = u2j_pkg::hex_digit(hi_unit[15:12]);
                body[3]  = u2j_pkg::hex_digit(hi_unit[11:8]);
                body[4]  = u2j_pkg::hex_digit(hi_unit[7:4]);
                body[5]  = u2j_pkg::hex_digit(hi_unit[3:0]);
                body[6]  = u2j_pkg::CH_BSLASH;
                body[7]  = u2j_pkg::CH_U;
                body[8]  = u2j_pkg::hex_digit(lo_unit[15:12]);
                body[9]  = u2j_pkg::hex_digit(lo_unit[11:8]);
                body[10] = u2j_pkg::hex_digit(lo_unit[7:4]);
                body[11] = u2j_pkg::hex_digit(lo_unit[3:0]);
                body_len = 4'd12;
            end
        end
    end

    // full result list: opening quote, body, then closing quote or error
    logic [7:0]    plan [u2j_pkg::MAX_RESULTS];
    logic [CW-1:0] plan_cnt;
    u2j_pkg::t_err plan_err;

    assign plan_cnt = CW'({3'b0, r_in_start}) + CW'(body_len) + CW'({3'b0, tail_any});
    assign plan_err = (byte_err != u2j_pkg::ERR_NONE) ? byte_err : tail_err;

    always_comb begin
        for (int k = 0; k < u2j_pkg::MAX_RESULTS; k++) begin
            logic [3:0] j;
            j = 4'(k) - {3'b0, r_in_start};
            if (4'(k) < {3'b0, r_in_start}) begin
                plan[k] = u2j_pkg::CH_QUOTE;
            end else if (j < body_len) begin
                plan[k] = body[j];
            end else begin
                plan[k] = tail_quote ? u2j_pkg::CH_QUOTE : u2j_pkg::CH_NUL;
            end
        end
    end

    // result shift register, entry 0 is on the port
    logic [7:0]    r_ob [u2j_pkg::MAX_RESULTS];
    logic [CW-1:0] r_left;
    u2j_pkg::t_err r_err;
    logic          advance;
    logic          ob_free;
    logic          load;

    assign advance = m_axis_tvalid && m_axis_tready;
    assign ob_free = (r_left == CW'(0)) || (r_left == CW'(1) && m_axis_tready);
    assign consume = r_in_valid && (ob_free || plan_cnt == CW'(0));
    assign load    = consume && (plan_cnt != CW'(0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_acc  <= '0;
            r_pend <= '0;
            r_len  <= '0;
            r_skip <= 1'b0;
        end else begin
            if (load) begin
                r_left <= plan_cnt;
            end else if (advance) begin
                r_left <= r_left - CW'(1);
            end
            if (consume) begin
                r_acc  <= n_acc;
                r_pend <= n_pend;
                r_len  <= n_len;
                r_skip <= n_skip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ob  <= plan;
            r_err <= plan_err;
        end else if (advance) begin
            for (int i = 0; i < u2j_pkg::MAX_RESULTS - 1; i++) begin
                r_ob[i] <= r_ob[i + 1];
            end
            r_ob[u2j_pkg::MAX_RESULTS - 1] <= u2j_pkg::CH_NUL;
        end
    end

    assign m_axis_tvalid = (r_left != CW'(0));
    assign m_axis_tdata  = r_ob[0];
    assign m_axis_tlast  = (r_left == CW'(1));
    // the error result is always the last one of its request
    assign m_axis_tuser  = m_axis_tlast ? r_err : u2j_pkg::ERR_NONE;

    `include "utf8_to_json_string_escaper_top_assert.svh"

    `U2J_ASSERT_NOW(a_err_is_last, m_axis_tvalid && m_axis_tuser != u2j_pkg::ERR_NONE, m_axis_tlast && m_axis_tdata == u2j_pkg::CH_NUL, "error result must be last with a zero byte")
    `U2J_ASSERT_NOW(a_left_bound, 1'b1, r_left <= CW'(u2j_pkg::MAX_RESULTS), "result count exceeds buffer depth")
    `U2J_ASSERT_NEXT(a_end_clears, consume && r_in_end, r_pend == 2'd0 && r_skip == 1'b0 && r_acc == 21'd0, "decoder state not cleared at string end")
    `U2J_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready, r_left == $past(r_left), "pending results changed while stalled")

endmodule

`default_nettype wire
